[rtl/core/image_convolution_3x3_defines.svh]
// ----------------------------------------------------------------------------
// Assertion helpers for the 3x3 convolution core
// Clocked on clk and disabled while rst_n is low in the including module.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONVOLUTION_3X3_DEFINES_SVH
`define IMAGE_CONVOLUTION_3X3_DEFINES_SVH

// A condition that holds at every clock edge.
`define IC3X3_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define IC3X3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define IC3X3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ic3x3_pkg.sv]
// ----------------------------------------------------------------------------
// ic3x3_pkg
// Shared types, widths and constants of the 3x3 convolution core.
// ----------------------------------------------------------------------------
package ic3x3_pkg;

  // Default maximum row length in samples.
  localparam int MAX_LINE_DEF   = 8192;
  // Fraction bits of the Q5.10 coefficients.
  localparam int COEF_FRAC_BITS = 10;

  // Field widths.
  localparam int SAMPLE_W   = 8;
  localparam int CH_W       = 2;
  localparam int LEN_W      = 14;
  localparam int SEEN_W     = LEN_W + 1;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int CFG_DATA_W = COEF_ROW_W;
  localparam int CFG_IDX_W  = 3;

  // Arithmetic widths: 9-bit signed tap times 16-bit coefficient, then sums.
  localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
  localparam int ROW_W  = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 3;

  // Result clamp limits.
  localparam int PIX_MAX = 255;
  localparam int UNIT    = 1;

  // Shift line length per row: taps at 0, stride and twice the stride.
  localparam int SHIFT_LEN = 7;
  localparam int SLOT_W    = 3;

  // Output queue; depth is a power of two.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Item codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Channel codes and strides.
  localparam logic [CH_W-1:0] CH_GRAY      = 2'd1;
  localparam logic [CH_W-1:0] STRIDE_GRAY  = 2'd1;
  localparam logic [CH_W-1:0] STRIDE_COLOR = 2'd3;

  // Register reset values.
  localparam logic [CH_W-1:0]       CHANNELS_RST  = 2'd1;
  localparam logic [LEN_W-1:0]      LINE_LEN_RST  = 14'd640;
  localparam logic [LEN_W-1:0]      FRAME_H_RST   = 14'd480;
  localparam logic [COEF_ROW_W-1:0] COEF_ZERO_RST = 48'h0;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST  = 48'h0000_0400_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS     = 3'd0,
    REG_LINE_LENGTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_COEF_TOP     = 3'd3,
    REG_COEF_MID     = 3'd4,
    REG_COEF_BOTTOM  = 3'd5
  } cfg_reg_t;

  // Masked 3x3 window handed to the multiply-accumulate stages.
  typedef struct packed {
    logic                                valid;
    logic                                last;
    logic [2:0][2:0][SAMPLE_W-1:0]       tap;
  } ic3x3_win_t;

  // One finished result.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [SAMPLE_W-1:0] pixel;
  } ic3x3_res_t;

endpackage

[rtl/core/ic3x3_stream_if.sv]
// ----------------------------------------------------------------------------
// ic3x3 stream interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface ic3x3_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [ic3x3_pkg::SAMPLE_W-1:0]     sample_in;

  modport source (output valid, output op, output sample_in, input ready);
  modport sink (input valid, input op, input sample_in, output ready);
endinterface

interface ic3x3_out_if;
  logic                               valid;
  logic                               ready;
  logic [ic3x3_pkg::SAMPLE_W-1:0]     pixel_out;
  logic                               frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

[rtl/core/image_convolution_3x3.sv]
// ----------------------------------------------------------------------------
// image_convolution_3x3
// 3x3 convolution of a raster sample stream with clamped 8-bit results.
// ----------------------------------------------------------------------------
// Usage: samples enter on in_ch (op selects a frame sample or a flush item
// that stands for zero padding), results leave on out_ch in raster order and
// frame_last marks the final result of a frame. Registers are written through
// cfg_we/cfg_index/cfg_wdata while no transfer is in progress.
// One sample per clock is sustained while in_ch.ready is high, bounded by the
// single write port and the two read ports of the line store.
// The result for a sample is produced once the item one row plus one stride
// later is transferred, and passes stages A and B, the multiply, row sum and
// result registers and the output FIFO. A write to line_length starts a reload
// of the row shift lines from the line store, during which in_ch.ready is low.
// Reset clears the counters, the shift lines and the fill count of the line
// store; no clearing pass is run, entries beyond the fill count read as zero.
// When the receiver stalls, up to eight results queue in the output FIFO;
// in_ch.ready drops once the queued and in-flight results reach that depth.
// ----------------------------------------------------------------------------
`include "image_convolution_3x3_defines.svh"

module image_convolution_3x3 #(
  parameter int MAX_LINE = ic3x3_pkg::MAX_LINE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ic3x3_in_if.sink                          in_ch,
  ic3x3_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [ic3x3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ic3x3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LS_DEPTH = 2 * MAX_LINE + 8;
  localparam int AW       = $clog2(LS_DEPTH);
  localparam int FW       = $clog2(LS_DEPTH + 1);
  localparam int LW       = ic3x3_pkg::LEN_W;
  localparam int SW       = ic3x3_pkg::SEEN_W;
  localparam int XW       = ic3x3_pkg::SAMPLE_W;
  localparam int NS       = ic3x3_pkg::SHIFT_LEN;
  localparam int QW       = ic3x3_pkg::FIFO_CW;

  // Configuration registers.
  logic [ic3x3_pkg::CH_W-1:0]               cfg_channels_r;
  logic [LW-1:0]                            cfg_line_length_r;
  logic [LW-1:0]                            cfg_frame_height_r;
  logic [2:0][ic3x3_pkg::COEF_ROW_W-1:0]    cfg_coef_r;

  // Effective geometry.
  logic [LW-1:0]                 len_eff, height_eff;
  logic [ic3x3_pkg::CH_W-1:0]    stride;
  logic [SW-1:0]                 delay;

  // Position counters.
  logic [LW-1:0] row_cnt_r, col_cnt_r;
  logic [SW-1:0] seen_r, seen_inc;
  logic [SW-1:0] row_p1, col_p1, col_ps;
  logic          emit_now, row_end, frame_end, last_now;
  logic [2:0]    row_ok, col_ok;

  // Line store addressing.
  logic [AW-1:0] wr_ptr_r;
  logic [FW-1:0] fill_r;
  logic [AW-1:0] dist1, dist2, rd_dist1, rd_dist2, raddr1, raddr2;
  logic          rd_ok1, rd_ok2;
  logic [XW-1:0] rdata1, rdata2, sample_v;

  // Shift line reload sequencer.
  logic                           rl_busy_r, rl_v_r;
  logic [ic3x3_pkg::SLOT_W-1:0]   rl_cnt_r, rl_slot_r;

  // Pipeline stages ahead of the multiply-accumulate.
  logic          in_fire, ready;
  logic          a_v_r, a_emit_r, a_last_r;
  logic [XW-1:0] a_sample_r;
  logic [1:0]    rd_ok_r;
  logic [2:0]    a_row_ok_r, a_col_ok_r;
  logic          b_v_r, b_last_r;
  logic [2:0]    b_row_ok_r, b_col_ok_r;
  logic [2:0][NS-1:0][XW-1:0] sl_r;

  // Result path.
  ic3x3_pkg::ic3x3_win_t win;
  ic3x3_pkg::ic3x3_res_t res;
  logic [QW-1:0]         fifo_cnt, inflight_r;
  logic [QW:0]           occupancy;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_channels_r     <= ic3x3_pkg::CHANNELS_RST;
      cfg_line_length_r  <= ic3x3_pkg::LINE_LEN_RST;
      cfg_frame_height_r <= ic3x3_pkg::FRAME_H_RST;
      cfg_coef_r[0]      <= ic3x3_pkg::COEF_ZERO_RST;
      cfg_coef_r[1]      <= ic3x3_pkg::COEF_MID_RST;
      cfg_coef_r[2]      <= ic3x3_pkg::COEF_ZERO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ic3x3_pkg::REG_CHANNELS:     cfg_channels_r     <= cfg_wdata[ic3x3_pkg::CH_W-1:0];
        ic3x3_pkg::REG_LINE_LENGTH:  cfg_line_length_r  <= cfg_wdata[LW-1:0];
        ic3x3_pkg::REG_FRAME_HEIGHT: cfg_frame_height_r <= cfg_wdata[LW-1:0];
        ic3x3_pkg::REG_COEF_TOP:     cfg_coef_r[0]      <= cfg_wdata;
        ic3x3_pkg::REG_COEF_MID:     cfg_coef_r[1]      <= cfg_wdata;
        ic3x3_pkg::REG_COEF_BOTTOM:  cfg_coef_r[2]      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective row length, height and stride.
  always_comb begin
    if (cfg_line_length_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(cfg_line_length_r) > 32'(MAX_LINE)) begin
      len_eff = LW'(MAX_LINE);
    end else begin
      len_eff = cfg_line_length_r;
    end
    height_eff = (cfg_frame_height_r == '0) ? LW'(1) : cfg_frame_height_r;
    stride     = (cfg_channels_r == ic3x3_pkg::CH_GRAY) ? ic3x3_pkg::STRIDE_GRAY
                                                        : ic3x3_pkg::STRIDE_COLOR;
    delay      = {1'b0, len_eff} + SW'(stride);
  end

  // Window position of the item being transferred and its edge masks.
  always_comb begin
    seen_inc  = (seen_r <= delay) ? seen_r + SW'(1) : seen_r;
    emit_now  = (seen_inc > delay);
    row_p1    = {1'b0, row_cnt_r} + SW'(1);
    col_p1    = {1'b0, col_cnt_r} + SW'(1);
    col_ps    = {1'b0, col_cnt_r} + SW'(stride);
    row_end   = (col_p1 >= {1'b0, len_eff});
    frame_end = (row_p1 >= {1'b0, height_eff});
    last_now  = emit_now && row_end && frame_end;
    // Row 0 is the newest row, column 0 the newest sample.
    row_ok[0] = (row_p1 < {1'b0, height_eff});
    row_ok[1] = 1'b1;
    row_ok[2] = (row_cnt_r != '0);
    col_ok[0] = (col_ps < {1'b0, len_eff});
    col_ok[1] = 1'b1;
    col_ok[2] = (col_cnt_r >= LW'(stride));
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      seen_r    <= '0;
    end else if (in_fire) begin
      seen_r <= last_now ? '0 : seen_inc;
      if (emit_now) begin
        if (last_now) begin
          row_cnt_r <= '0;
          col_cnt_r <= '0;
        end else if (row_end) begin
          row_cnt_r <= row_p1[LW-1:0];
          col_cnt_r <= '0;
        end else begin
          col_cnt_r <= col_p1[LW-1:0];
        end
      end
    end
  end

  // Read distances from the write pointer: one and two rows back, or the
  // shift line slots during a reload.
  always_comb begin
    dist1 = AW'(len_eff);
    dist2 = dist1 + dist1;
    if (rl_busy_r) begin
      rd_dist1 = dist1 + AW'(rl_cnt_r) + AW'(1);
      rd_dist2 = dist2 + AW'(rl_cnt_r) + AW'(1);
    end else begin
      rd_dist1 = dist1;
      rd_dist2 = dist2;
    end
    raddr1 = (wr_ptr_r >= rd_dist1) ? wr_ptr_r - rd_dist1
                                    : wr_ptr_r + AW'(LS_DEPTH) - rd_dist1;
    raddr2 = (wr_ptr_r >= rd_dist2) ? wr_ptr_r - rd_dist2
                                    : wr_ptr_r + AW'(LS_DEPTH) - rd_dist2;
    // Entries older than the number written since reset read as zero.
    rd_ok1 = (FW'(rd_dist1) <= fill_r);
    rd_ok2 = (FW'(rd_dist2) <= fill_r);
  end

  assign sample_v = (in_ch.op == ic3x3_pkg::OP_FLUSH) ? '0 : in_ch.sample_in;

  // Write pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (in_fire) begin
      wr_ptr_r <= (wr_ptr_r == AW'(LS_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (fill_r != FW'(LS_DEPTH)) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  ic3x3_line_mem #(
    .DEPTH (LS_DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk    (clk),
    .we     (in_fire),
    .waddr  (wr_ptr_r),
    .wdata  (sample_v),
    .raddr0 (raddr1),
    .raddr1 (raddr2),
    .rdata0 (rdata1),
    .rdata1 (rdata2)
  );

  // Reload of the older rows' shift lines after a row length change.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_busy_r <= 1'b0;
      rl_cnt_r  <= '0;
      rl_v_r    <= 1'b0;
    end else begin
      rl_v_r <= rl_busy_r;
      if (cfg_we && (cfg_index == ic3x3_pkg::REG_LINE_LENGTH)) begin
        rl_busy_r <= 1'b1;
        rl_cnt_r  <= '0;
      end else if (rl_busy_r) begin
        if (rl_cnt_r == ic3x3_pkg::SLOT_W'(NS - 1)) begin
          rl_busy_r <= 1'b0;
        end
        rl_cnt_r <= rl_cnt_r + ic3x3_pkg::SLOT_W'(1);
      end
    end
  end

  // Stage A: sideband of the item whose row reads are in flight.
  always_ff @(posedge clk) begin
    a_sample_r <= sample_v;
    a_emit_r   <= emit_now;
    a_last_r   <= last_now;
    a_row_ok_r <= row_ok;
    a_col_ok_r <= col_ok;
    rd_ok_r    <= {rd_ok2, rd_ok1};
    rl_slot_r  <= rl_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire;
    end
  end

  // Stage B: shift the three rows, or drop reloaded taps into place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r <= '0;
    end else if (a_v_r) begin
      sl_r[0] <= {sl_r[0][NS-2:0], a_sample_r};
      sl_r[1] <= {sl_r[1][NS-2:0], (rd_ok_r[0] ? rdata1 : XW'(0))};
      sl_r[2] <= {sl_r[2][NS-2:0], (rd_ok_r[1] ? rdata2 : XW'(0))};
    end else if (rl_v_r) begin
      sl_r[1][rl_slot_r] <= rd_ok_r[0] ? rdata1 : XW'(0);
      sl_r[2][rl_slot_r] <= rd_ok_r[1] ? rdata2 : XW'(0);
    end
  end

  always_ff @(posedge clk) begin
    b_last_r   <= a_last_r;
    b_row_ok_r <= a_row_ok_r;
    b_col_ok_r <= a_col_ok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r && a_emit_r;
    end
  end

  // Pick the taps at zero, one and two strides and blank those off the frame.
  always_comb begin
    win.valid = b_v_r;
    win.last  = b_last_r;
    for (int r = 0; r < 3; r++) begin
      win.tap[r][0] = sl_r[r][0];
      win.tap[r][1] = (stride == ic3x3_pkg::STRIDE_GRAY) ? sl_r[r][1] : sl_r[r][3];
      win.tap[r][2] = (stride == ic3x3_pkg::STRIDE_GRAY) ? sl_r[r][2] : sl_r[r][6];
      for (int c = 0; c < 3; c++) begin
        if (!(b_row_ok_r[r] && b_col_ok_r[c])) begin
          win.tap[r][c] = '0;
        end
      end
    end
  end

  ic3x3_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .win   (win),
    .coef  (cfg_coef_r),
    .res   (res)
  );

  ic3x3_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res),
    .out_ch (out_ch),
    .count  (fifo_cnt)
  );

  // Credits: results in flight plus queued results never exceed the FIFO.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + QW'(in_fire && emit_now) - QW'(res.valid);
    end
  end

  assign occupancy   = {1'b0, inflight_r} + {1'b0, fifo_cnt};
  assign ready       = !rl_busy_r && (occupancy < (QW + 1)'(ic3x3_pkg::FIFO_DEPTH));
  assign in_ch.ready = ready;
  assign in_fire     = in_ch.valid && ready;

  // Checks.
  `IC3X3_ASSERT_NOW(a_credit_bound, occupancy <= (QW + 1)'(ic3x3_pkg::FIFO_DEPTH), "result credits overrun the output FIFO")
  `IC3X3_ASSERT_IMP(a_no_transfer_in_reload, rl_busy_r, !in_ch.ready, "input ready during shift line reload")
  `IC3X3_ASSERT_IMP(a_shift_or_reload, a_v_r, !rl_v_r, "shift and reload hit the shift lines together")
  `IC3X3_ASSERT_NXT(a_frame_restart, in_fire && last_now, row_cnt_r == '0 && col_cnt_r == '0 && seen_r == '0, "counters not cleared after the last result of a frame")
  `IC3X3_ASSERT_NOW(a_fill_bound, fill_r <= FW'(LS_DEPTH), "line store fill count beyond depth")

endmodule

[rtl/core/ic3x3_line_mem.sv]
// ----------------------------------------------------------------------------
// ic3x3_line_mem
// Sample history: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ic3x3_line_mem #(
  parameter int DEPTH = 2 * ic3x3_pkg::MAX_LINE_DEF + 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [ic3x3_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                  raddr0,
  input  logic [AW-1:0]                  raddr1,
  output logic [ic3x3_pkg::SAMPLE_W-1:0] rdata0,
  output logic [ic3x3_pkg::SAMPLE_W-1:0] rdata1
);

  logic [ic3x3_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // Write the newest sample.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both reads are registered.
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/core/ic3x3_mac.sv]
// ----------------------------------------------------------------------------
// ic3x3_mac
// Nine products, row sums, total and clamp to an 8-bit sample.
// ----------------------------------------------------------------------------
module ic3x3_mac (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ic3x3_pkg::ic3x3_win_t                     win,
  input  logic [2:0][ic3x3_pkg::COEF_ROW_W-1:0]     coef,
  output ic3x3_pkg::ic3x3_res_t                     res
);

  localparam int PW = ic3x3_pkg::PROD_W;
  localparam int RW = ic3x3_pkg::ROW_W;
  localparam int AW = ic3x3_pkg::ACC_W;
  localparam int CW = ic3x3_pkg::COEF_W;
  localparam int F  = ic3x3_pkg::COEF_FRAC_BITS;
  localparam logic signed [AW-1:0] ACC_LO = AW'(ic3x3_pkg::UNIT << F);
  localparam logic signed [AW-1:0] ACC_HI = AW'(ic3x3_pkg::PIX_MAX << F);

  logic signed [PW-1:0] tap_s [3][3];
  logic signed [PW-1:0] coef_s [3][3];
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [RW-1:0] row_sum_r [3];
  logic signed [AW-1:0] acc;
  logic [ic3x3_pkg::SAMPLE_W-1:0] pix;
  logic c_v_r, c_last_r, d_v_r, d_last_r;

  // Sign-extend taps and coefficients to product width.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap_s[r][c]  = PW'(signed'({1'b0, win.tap[r][c]}));
        coef_s[r][c] = PW'(signed'(coef[r][CW*c +: CW]));
      end
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= tap_s[r][c] * coef_s[r][c];
      end
    end
    c_last_r <= win.last;
  end

  // Row sum stage.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      row_sum_r[r] <= RW'(prod_r[r][0]) + RW'(prod_r[r][1]) + RW'(prod_r[r][2]);
    end
    d_last_r <= c_last_r;
  end

  // Total and clamp: below one gives zero, above full scale saturates.
  always_comb begin
    acc = AW'(row_sum_r[0]) + AW'(row_sum_r[1]) + AW'(row_sum_r[2]);
    if (acc < ACC_LO) begin
      pix = '0;
    end else if (acc > ACC_HI) begin
      pix = ic3x3_pkg::SAMPLE_W'(ic3x3_pkg::PIX_MAX);
    end else begin
      pix = acc[F +: ic3x3_pkg::SAMPLE_W];
    end
  end

  // Result register and stage valid bits; only the valid bits are reset.
  always_ff @(posedge clk) begin
    res.pixel <= pix;
    res.last  <= d_last_r;
    if (!rst_n) begin
      c_v_r     <= 1'b0;
      d_v_r     <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      c_v_r     <= win.valid;
      d_v_r     <= c_v_r;
      res.valid <= d_v_r;
    end
  end

endmodule

[rtl/core/ic3x3_out_fifo.sv]
// ----------------------------------------------------------------------------
// ic3x3_out_fifo
// Small result queue that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module ic3x3_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ic3x3_pkg::ic3x3_res_t             push,
  ic3x3_out_if.source                       out_ch,
  output logic [ic3x3_pkg::FIFO_CW-1:0]     count
);

  localparam int D  = ic3x3_pkg::FIFO_DEPTH;
  localparam int PA = ic3x3_pkg::FIFO_AW;
  localparam int CW = ic3x3_pkg::FIFO_CW;

  logic [ic3x3_pkg::SAMPLE_W-1:0] pix_q [D];
  logic                           last_q [D];
  logic [PA-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (count_r != '0);
  assign out_ch.pixel_out = pix_q[rd_ptr_r];
  assign out_ch.frame_last = last_q[rd_ptr_r];
  assign count            = count_r;

  // Storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      pix_q[wr_ptr_r]  <= push.pixel;
      last_q[wr_ptr_r] <= push.last;
    end
  end

  // Pointers and fill level; the credit check upstream keeps pushes in room.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + PA'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PA'(1);
      end
      count_r <= count_r + CW'(push.valid) - CW'(pop);
    end
  end

endmodule
